// ===== rtl/wpsm_pkg.sv =====
// Package: shared constants, types and the byte fold for the wildcard matcher.
`default_nettype none
package wpsm_pkg;

   // Configured pattern limits
   localparam int PAT_MAX_DEFAULT = 16;
   localparam int WIN_BYTES       = 16;   // pattern registers hold 16 bytes
   localparam int PAT_BITS        = 8 * WIN_BYTES;
   localparam int LEN_W           = 5;
   localparam int CSR_DATA_W      = 64;
   localparam int CSR_INDEX_W     = 3;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_PAT_LO  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PAT_HI  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PAT_LEN = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_KIND    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_CASE    = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_NEGATE  = 3'd5;

   typedef enum logic [1:0] {
      KIND_EXACT  = 2'd0,
      KIND_PREFIX = 2'd1,
      KIND_SUFFIX = 2'd2,
      KIND_SUBSTR = 2'd3
   } match_kind_type;

   // Per-cycle control broadcast along the cell row
   typedef struct packed {
      logic advance;   // a subject byte is taken this cycle
      logic restart;   // the subject ends this cycle
      logic fold_en;   // ASCII case fold on
   } cell_ctrl_type;

   // Lower-cases A..Z when folding is on
   function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic fold_en);
      logic [7:0] r;
      r = c;
      if (fold_en && (c >= 8'h41) && (c <= 8'h5A)) begin
         r = c + 8'h20;
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/wildcard_pattern_string_matcher_core.sv =====
// Top level: wildcard string matcher (exact, prefix, suffix, substring) over a row of cells.
//
//   channel | ports                                   | direction | handshake
//   --------+-----------------------------------------+-----------+-----------------
//   req     | req_char_byte, req_last_byte,           | in        | valid / stall
//           | req_empty_subject                       |           |
//   rsp     | rsp_matched                             | out       | valid / stall
//   csr     | csr_write, csr_index, csr_data          | in        | write enable only
//
// One subject byte is taken per cycle; the whole window compare is done by the
// cell row in the cycle the byte is taken, so a word is accepted every cycle that
// req_stall is low. A subject's result is registered in the output register or skid slot.
// Reset (synchronous, active high) loads the register defaults and clears the
// subject state and the output buffer.
// A stalled result waits in the output register; a second one goes to the skid
// slot, and req_stall rises only while that slot is occupied.
`default_nettype none
module wildcard_pattern_string_matcher_core #(
   parameter int PAT_MAX = wpsm_pkg::PAT_MAX_DEFAULT
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // subject bytes
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic [7:0]                         req_char_byte,
   input  wire logic                               req_last_byte,
   input  wire logic                               req_empty_subject,
   // results
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic                                    rsp_matched,
   // register writes
   input  wire logic                               csr_write,
   input  wire logic [wpsm_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [wpsm_pkg::CSR_DATA_W-1:0]    csr_data
);

   // Usable pattern length: the cell row is never longer than the pattern registers.
   localparam int LIM   = (PAT_MAX < wpsm_pkg::WIN_BYTES) ? PAT_MAX : wpsm_pkg::WIN_BYTES;
   localparam int CNT_W = $clog2(LIM + 2);
   localparam int LEN_W = wpsm_pkg::LEN_W;
   localparam int PB_W  = $clog2(wpsm_pkg::WIN_BYTES);

   // ---------------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------------
   logic [wpsm_pkg::PAT_BITS-1:0] pattern_ff;    // {high word, low word}
   logic [LEN_W-1:0]              pat_len_ff;
   wpsm_pkg::match_kind_type      kind_ff;
   logic                          case_sens_ff;
   logic                          negate_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff   <= '0;
         pat_len_ff   <= '0;
         kind_ff      <= wpsm_pkg::KIND_EXACT;
         case_sens_ff <= 1'b1;
         negate_ff    <= 1'b0;
      end else if (csr_write) begin
         unique case (csr_index)
            wpsm_pkg::CSR_PAT_LO:  pattern_ff[63:0]   <= csr_data;
            wpsm_pkg::CSR_PAT_HI:  pattern_ff[127:64] <= csr_data;
            wpsm_pkg::CSR_PAT_LEN: pat_len_ff         <= csr_data[LEN_W-1:0];
            wpsm_pkg::CSR_KIND:    kind_ff <= wpsm_pkg::match_kind_type'(csr_data[1:0]);
            wpsm_pkg::CSR_CASE:    case_sens_ff       <= csr_data[0];
            wpsm_pkg::CSR_NEGATE:  negate_ff          <= csr_data[0];
            default: ;   // unused indexes are ignored
         endcase
      end
   end

   // pattern_length beyond the row saturates
   logic [LEN_W-1:0] eff_len;
   assign eff_len = (pat_len_ff > LEN_W'(LIM)) ? LEN_W'(LIM) : pat_len_ff;

   // ---------------------------------------------------------------------------
   // Handshake
   // ---------------------------------------------------------------------------
   logic buf_full;
   logic in_go;      // word accepted
   logic end_go;     // word closes the subject
   logic byte_go;    // word carries a subject byte

   assign req_stall = buf_full;
   assign in_go     = req_valid & ~buf_full;
   assign end_go    = in_go & (req_last_byte | req_empty_subject);
   assign byte_go   = in_go & ~req_empty_subject;

   wpsm_pkg::cell_ctrl_type cell_ctrl;
   assign cell_ctrl.advance = byte_go;
   assign cell_ctrl.restart = end_go;
   assign cell_ctrl.fold_en = ~case_sens_ff;

   // ---------------------------------------------------------------------------
   // Cell row: cell i holds the (i+1)-th newest byte, which becomes window slot
   // i+1 when a new byte comes in; slot 0 is the incoming byte itself.
   // Each slot is compared with the pattern as it stands now.
   // ---------------------------------------------------------------------------
   logic [LIM:0][7:0]   win_pat;     // pattern byte lined up with each window slot
   logic [LIM:0]        win_eq;
   logic [LIM-1:0][7:0] row_bytes;
   logic [LIM-1:0]      eq_vec;

   // slot s lines up with pattern byte eff_len-1-s; slots at or past eff_len are masked
   always_comb begin
      for (int s = 0; s <= LIM; s++) begin
         win_pat[s] = pattern_ff[8*int'(PB_W'(eff_len - LEN_W'(s + 1))) +: 8];
      end
   end

   assign win_eq[0] = wpsm_pkg::fold_byte(req_char_byte, cell_ctrl.fold_en)
                      == wpsm_pkg::fold_byte(win_pat[0], cell_ctrl.fold_en);

   for (genvar g = 0; g < LIM; g++) begin : g_cell
      logic [7:0] shift_in;
      if (g == 0) begin : g_head
         assign shift_in = req_char_byte;
      end else begin : g_link
         assign shift_in = row_bytes[g-1];
      end
      wpsm_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (cell_ctrl),
         .char_byte (req_char_byte),
         .pat_byte  (pattern_ff[8*g +: 8]),
         .shift_in  (shift_in),
         .win_pat   (win_pat[g+1]),
         .eq        (eq_vec[g]),
         .win_eq    (win_eq[g+1]),
         .byte_ff   (row_bytes[g])
      );
   end

   // ---------------------------------------------------------------------------
   // Subject state
   // ---------------------------------------------------------------------------
   logic [CNT_W-1:0] seen_ff, seen_in;
   logic             prefix_ok_ff, prefix_ok_in;
   logic             sub_found_ff, sub_found_in;

   logic             prefix_fail;
   logic             window_hit;
   logic             long_enough;
   logic             match_raw;

   always_comb begin
      prefix_fail = 1'b0;
      window_hit  = 1'b1;
      for (int i = 0; i < LIM; i++) begin
         // byte at position i of the subject against pattern byte i
         if ((LEN_W'(seen_ff) == LEN_W'(i)) && (LEN_W'(i) < eff_len) && !eq_vec[i]) begin
            prefix_fail = 1'b1;
         end
      end
      // newest eff_len bytes against the whole pattern
      for (int s = 0; s <= LIM; s++) begin
         if ((LEN_W'(s) < eff_len) && !win_eq[s]) begin
            window_hit = 1'b0;
         end
      end
   end

   always_comb begin
      seen_in      = (seen_ff < CNT_W'(LIM + 1)) ? seen_ff + CNT_W'(1) : seen_ff;
      prefix_ok_in = prefix_ok_ff & ~prefix_fail;
      long_enough  = LEN_W'(seen_in) >= eff_len;
      sub_found_in = sub_found_ff | (long_enough & window_hit);

      if (req_empty_subject) begin
         match_raw = (eff_len == '0);
      end else begin
         case (kind_ff)
            wpsm_pkg::KIND_EXACT:  match_raw = (LEN_W'(seen_in) == eff_len) & prefix_ok_in;
            wpsm_pkg::KIND_PREFIX: match_raw = long_enough & prefix_ok_in;
            wpsm_pkg::KIND_SUFFIX: match_raw = long_enough & window_hit;
            default:               match_raw = (eff_len == '0) | sub_found_in;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset || end_go) begin
         seen_ff      <= '0;
         prefix_ok_ff <= 1'b1;
         sub_found_ff <= 1'b0;
      end else if (byte_go) begin
         seen_ff      <= seen_in;
         prefix_ok_ff <= prefix_ok_in;
         sub_found_ff <= sub_found_in;
      end
   end

   // ---------------------------------------------------------------------------
   // Result buffer
   // ---------------------------------------------------------------------------
   wpsm_out_buf u_out_buf (
      .clock       (clock),
      .reset       (reset),
      .res_go      (end_go),
      .res_matched (match_raw ^ negate_ff),
      .full        (buf_full),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_matched (rsp_matched)
   );

endmodule
`default_nettype wire

// ===== rtl/wpsm_cell.sv =====
// One matcher cell: holds one window byte and compares subject bytes with its pattern bytes.
`default_nettype none
module wpsm_cell (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire wpsm_pkg::cell_ctrl_type ctrl,
   input  wire logic [7:0]              char_byte,  // incoming subject byte
   input  wire logic [7:0]              pat_byte,   // pattern byte at this subject position
   input  wire logic [7:0]              shift_in,   // byte moving in from the neighbour
   input  wire logic [7:0]              win_pat,    // pattern byte lined up with the held byte
   output logic                         eq,         // incoming byte against pat_byte
   output logic                         win_eq,     // held byte against win_pat
   output logic [7:0]                   byte_ff
);

   assign eq     = wpsm_pkg::fold_byte(char_byte, ctrl.fold_en)
                   == wpsm_pkg::fold_byte(pat_byte, ctrl.fold_en);
   assign win_eq = wpsm_pkg::fold_byte(byte_ff, ctrl.fold_en)
                   == wpsm_pkg::fold_byte(win_pat, ctrl.fold_en);

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_ff <= '0;
      end else if (ctrl.restart) begin
         byte_ff <= '0;
      end else if (ctrl.advance) begin
         byte_ff <= shift_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/wpsm_out_buf.sv =====
// Two-word result buffer: output register plus skid slot.
`default_nettype none
module wpsm_out_buf (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic res_go,
   input  wire logic res_matched,
   output logic      full,
   output logic      rsp_valid,
   input  wire logic rsp_stall,
   output logic      rsp_matched
);

   logic main_valid_ff, main_valid_in, main_data_ff, main_data_in;
   logic skid_valid_ff, skid_valid_in, skid_data_ff, skid_data_in;
   logic main_free;

   assign main_free = ~main_valid_ff | ~rsp_stall;

   always_comb begin
      main_valid_in = main_valid_ff;
      main_data_in  = main_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         // nothing new arrives while the skid slot is held
         if (main_free) begin
            main_valid_in = 1'b1;
            main_data_in  = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (main_free) begin
         main_valid_in = res_go;
         main_data_in  = res_matched;
      end else if (res_go) begin
         skid_valid_in = 1'b1;
         skid_data_in  = res_matched;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_data_ff <= main_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign full        = skid_valid_ff;
   assign rsp_valid   = main_valid_ff;
   assign rsp_matched = main_data_ff;

endmodule
`default_nettype wire

// ===== test/wildcard_pattern_string_matcher_core_tb.sv =====
// Testbench: self-checking stimulus and match prediction for the wildcard string matcher core.
module wildcard_pattern_string_matcher_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import wpsm_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_WAIT  = 4;    // the result is held in a register behind the last word

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [7:0]             req_char_byte = 8'h00;
   logic                   req_last_byte = 1'b0;
   logic                   req_empty_subject = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic                   rsp_matched;
   logic                   csr_write = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_PAT_LO;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   // register image as the block should hold it
   logic [63:0]    cfg_pat_lo;
   logic [63:0]    cfg_pat_hi;
   logic [4:0]     cfg_len;
   match_kind_type cfg_kind;
   logic           cfg_case_exact;
   logic           cfg_negate;

   // subject state: newest byte at index 0
   logic [7:0] recent[16];
   logic [4:0] seen_count;
   logic       prefix_ok;
   logic       window_found;

   logic       expected_matches[$];
   logic [7:0] subject_bytes[$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_cycles   = 0;
   int items_sent    = 0;
   int failures      = 0;
   int cycle_count   = 0;

   wildcard_pattern_string_matcher_core dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_char_byte     (req_char_byte),
      .req_last_byte     (req_last_byte),
      .req_empty_subject (req_empty_subject),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_matched       (rsp_matched),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Hard stop if the handshake locks up
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------- prediction

   function automatic logic [7:0] pattern_byte(int i);
      logic [127:0] pat;
      pat = {cfg_pat_hi, cfg_pat_lo};
      return pat[8*i +: 8];
   endfunction

   function automatic logic [7:0] to_lower(logic [7:0] c);
      if (!cfg_case_exact && c >= 8'h41 && c <= 8'h5A) begin
         return c + 8'h20;
      end
      return c;
   endfunction

   function automatic logic bytes_equal(logic [7:0] a, logic [7:0] b);
      return to_lower(a) == to_lower(b);
   endfunction

   // newest n bytes line up with pattern bytes 0..n-1
   function automatic logic window_matches(int n);
      int i;
      for (i = 0; i < n; i++) begin
         if (!bytes_equal(recent[n-1-i], pattern_byte(i))) begin
            return 1'b0;
         end
      end
      return 1'b1;
   endfunction

   function automatic int pattern_span();
      return (cfg_len > 5'd16) ? 16 : int'(cfg_len);
   endfunction

   task automatic clear_subject();
      int i;
      for (i = 0; i < 16; i++) begin
         recent[i] = 8'h00;
      end
      seen_count   = '0;
      prefix_ok    = 1'b1;
      window_found = 1'b0;
   endtask

   // Folds one accepted word into the subject state; queues a result at subject end
   task automatic predict_word(logic [7:0] c, logic last, logic empty);
      int   n;
      int   i;
      logic m;
      logic done;
      n    = pattern_span();
      done = 1'b1;
      m    = 1'b0;
      if (empty) begin
         m = (n == 0);
      end else begin
         if (seen_count < n && !bytes_equal(c, pattern_byte(seen_count))) begin
            prefix_ok = 1'b0;
         end
         for (i = 15; i > 0; i--) begin
            recent[i] = recent[i-1];
         end
         recent[0] = c;
         if (seen_count < 5'd17) begin
            seen_count++;
         end
         if (seen_count >= n && window_matches(n)) begin
            window_found = 1'b1;
         end
         if (!last) begin
            done = 1'b0;
         end else begin
            case (cfg_kind)
               KIND_EXACT:  m = (seen_count == n) && prefix_ok;
               KIND_PREFIX: m = (seen_count >= n) && prefix_ok;
               KIND_SUFFIX: m = (seen_count >= n) && window_matches(n);
               default:     m = (n == 0) || window_found;
            endcase
         end
      end
      if (done) begin
         expected_matches.push_back(cfg_negate ? !m : m);
         clear_subject();
      end
   endtask

   // ---------------------------------------------------------------- drivers

   task automatic send_word(logic [7:0] c, logic last, logic empty);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_char_byte     <= c;
      req_last_byte     <= last;
      req_empty_subject <= empty;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      predict_word(c, last, empty);
      items_sent++;
   endtask

   // An empty queue goes out as a single empty-subject word
   task automatic send_subject();
      int i;
      if (subject_bytes.size() == 0) begin
         send_word(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
      end else begin
         for (i = 0; i < subject_bytes.size(); i++) begin
            send_word(subject_bytes[i], i == subject_bytes.size() - 1, 1'b0);
         end
      end
   endtask

   task automatic send_text(string s);
      int i;
      subject_bytes.delete();
      for (i = 0; i < s.len(); i++) begin
         subject_bytes.push_back(s[i]);
      end
      send_subject();
   endtask

   // Stop offering words and wait until every result is in, plus the pipeline tail
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_matches.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, logic [63:0] data);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      case (idx)
         CSR_PAT_LO:  cfg_pat_lo     = data;
         CSR_PAT_HI:  cfg_pat_hi     = data;
         CSR_PAT_LEN: cfg_len        = data[4:0];
         CSR_KIND:    cfg_kind       = match_kind_type'(data[1:0]);
         CSR_CASE:    cfg_case_exact = data[0];
         CSR_NEGATE:  cfg_negate     = data[0];
         default: ;
      endcase
   endtask

   task automatic program_matcher(logic [63:0] lo, logic [63:0] hi, logic [4:0] len,
                                  match_kind_type kind, logic case_exact, logic neg);
      write_reg(CSR_PAT_LO, lo);
      write_reg(CSR_PAT_HI, hi);
      write_reg(CSR_PAT_LEN, 64'(len));
      write_reg(CSR_KIND, 64'(kind));
      write_reg(CSR_CASE, 64'(case_exact));
      write_reg(CSR_NEGATE, 64'(neg));
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   // ---------------------------------------------------------------- random content

   // Mostly a small letter set so that hits and case folding turn up often
   function automatic logic [7:0] pick_char();
      case ($urandom_range(5))
         0: return 8'h61;   // a
         1: return 8'h41;   // A
         2: return 8'h62;   // b
         3: return 8'h42;   // B
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   function automatic logic [7:0] vary_case(logic [7:0] c);
      logic [7:0] low;
      low = c | 8'h20;
      if (low >= 8'h61 && low <= 8'h7A && $urandom_range(1)) begin
         return c ^ 8'h20;
      end
      return c;
   endfunction

   task automatic program_random_config();
      logic [127:0] pat;
      logic [4:0]   len;
      int           i;
      for (i = 0; i < 16; i++) begin
         pat[8*i +: 8] = pick_char();
      end
      case ($urandom_range(9))
         0:       len = 5'd0;
         1:       len = 5'd16;
         2:       len = 5'($urandom_range(17, 31));   // saturates to 16
         default: len = 5'($urandom_range(1, 6));
      endcase
      program_matcher(pat[63:0], pat[127:64], len, match_kind_type'($urandom_range(3)),
                      1'($urandom_range(1)), 1'($urandom_range(1)));
   endtask

   // Subjects of random bytes, or built around the pattern: plain, framed, clipped, or one byte spoilt
   task automatic build_subject();
      int n;
      int shape;
      int i;
      n = pattern_span();
      subject_bytes.delete();
      shape = $urandom_range(4);
      if (shape == 0) begin
         repeat ($urandom_range(6)) subject_bytes.push_back(pick_char());
      end else begin
         if (shape == 2) begin
            repeat ($urandom_range(4)) subject_bytes.push_back(pick_char());
         end
         for (i = 0; i < n; i++) begin
            subject_bytes.push_back(vary_case(pattern_byte(i)));
         end
         if (shape == 2) begin
            repeat ($urandom_range(4)) subject_bytes.push_back(pick_char());
         end
         if (shape == 3 && subject_bytes.size() > 0) begin
            if ($urandom_range(1)) begin
               void'(subject_bytes.pop_back());
            end else begin
               void'(subject_bytes.pop_front());
            end
         end
         if (shape == 4 && subject_bytes.size() > 0) begin
            subject_bytes[$urandom_range(subject_bytes.size() - 1)] = pick_char();
         end
      end
   endtask

   // ---------------------------------------------------------------- result side

   // Receiver: a forced hold-off takes priority over random stalls
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_cycles = hold_cycles - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   always @(posedge clock) begin : check_results
      logic want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_matches.size() == 0) begin
            $display("%0t: rsp_matched expected none, got %0b", $time, rsp_matched);
            failures++;
         end else begin
            want = expected_matches.pop_front();
            if (rsp_matched !== want) begin
               $display("%0t: rsp_matched expected %0b, got %0b", $time, want, rsp_matched);
               failures++;
            end
         end
      end
   end

   // ---------------------------------------------------------------- tests

   // Empty subject: matches only an empty pattern, and drops bytes taken so far
   task automatic test_empty_subject();
      settle();
      program_matcher('0, '0, 5'd0, KIND_EXACT, 1'b1, 1'b0);
      send_word(8'h00, 1'b1, 1'b1);
      send_word(8'h71, 1'b0, 1'b0);
      send_word(8'hFF, 1'b0, 1'b1);   // last flag low, still ends the subject
      settle();
      program_matcher('0, '0, 5'd3, KIND_SUBSTR, 1'b1, 1'b0);
      send_word(8'h5A, 1'b1, 1'b1);
   endtask

   // Pattern "Ab" folded, one subject per kind
   task automatic test_match_kinds();
      match_kind_type k;
      k = KIND_EXACT;
      repeat (4) begin
         settle();
         program_matcher(64'h6241, '0, 5'd2, k, 1'b0, 1'b0);
         case (k)
            KIND_EXACT:  send_text("ab");
            KIND_PREFIX: send_text("zab");
            KIND_SUFFIX: send_text("zab");
            default:     send_text("zaBz");
         endcase
         k = match_kind_type'(k + 1);
      end
   endtask

   // All-ones pattern with an oversize length, then an all-zero one-byte pattern
   task automatic test_pattern_extremes();
      settle();
      program_matcher('1, '1, 5'd31, KIND_SUFFIX, 1'b1, 1'b1);
      send_word(8'hFF, 1'b1, 1'b0);   // shorter than the pattern
      settle();
      program_matcher('0, '0, 5'd1, KIND_EXACT, 1'b0, 1'b0);
      send_word(8'h00, 1'b1, 1'b0);
   endtask

   // Registers change between two words of one subject; earlier bytes stand
   task automatic test_config_mid_subject();
      settle();
      program_matcher(64'h61, '0, 5'd1, KIND_PREFIX, 1'b1, 1'b0);
      send_word(8'h61, 1'b0, 1'b0);
      settle();
      program_matcher(64'h61, '0, 5'd1, KIND_EXACT, 1'b1, 1'b1);
      send_word(8'h62, 1'b1, 1'b0);
   endtask

   // Receiver holds off while one-byte subjects keep coming, so req_stall must rise
   task automatic test_back_pressure();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      settle();
      program_matcher(64'h41, '0, 5'd1, KIND_SUBSTR, 1'b0, 1'b0);
      hold_cycles = 80;
      repeat (30) begin
         send_word(pick_char(), 1'b1, 1'b0);
      end
   endtask

   task automatic test_random_traffic(int send_pct, int recv_pct, int quota);
      int target;
      int r;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      repeat (4) begin
         settle();
         program_random_config();
         target = items_sent + quota / 4;
         while (items_sent < target) begin
            r = $urandom_range(99);
            if (r < 6) begin
               // stray word: random byte and flags, may split or cut short a subject
               send_word(8'($urandom_range(255)), 1'($urandom_range(1)), 1'($urandom_range(1)));
            end else begin
               build_subject();
               send_subject();
            end
         end
      end
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin
      cfg_pat_lo     = '0;
      cfg_pat_hi     = '0;
      cfg_len        = '0;
      cfg_kind       = KIND_EXACT;
      cfg_case_exact = 1'b1;
      cfg_negate     = 1'b0;
      clear_subject();

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 20;
      recv_idle_pct = 20;
      test_empty_subject();
      test_match_kinds();
      test_pattern_extremes();
      test_config_mid_subject();
      test_back_pressure();

      test_random_traffic(36, 78, 470);
      test_random_traffic(78, 36, 470);
      test_random_traffic(0, 0, 470);

      settle();
      repeat (10) @(posedge clock);
      if (failures == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
